// File: hdl/bms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

  // field widths
  localparam int MODE_W     = 2;
  localparam int NOW_W      = 32;
  localparam int ADC_W      = 12;
  localparam int SUM_W      = 16;
  localparam int MV_W       = 14;
  localparam int LVL_W      = 8;
  localparam int FD_W       = 16;
  localparam int PER_W      = 32;
  localparam int TO_W       = 16;
  localparam int SETTLE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_POLL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FORCE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 2'd3;

  // register reset values
  localparam logic [FD_W-1:0]     FIRST_DELAY_RST = 16'd750;
  localparam logic [PER_W-1:0]    PERIOD_RST      = 32'd45000;
  localparam logic [TO_W-1:0]     TIMEOUT_RST     = 16'd100;
  localparam logic [SETTLE_W-1:0] SETTLE_RST      = 8'd5;

  localparam logic [ADC_W-1:0] ADC_MAX = '1;

  // millivolt scale avg*MV_NUM/MV_DEN as a fixed-point reciprocal multiply
  localparam longint unsigned MV_NUM   = 64'd7400;
  localparam longint unsigned MV_DEN   = 64'h0ab0;
  localparam int              MV_SHIFT = 24;
  localparam longint unsigned MV_MULT  = ((MV_NUM << MV_SHIFT) + MV_DEN - 64'd1) / MV_DEN;
  localparam int              MV_MULT_W = $clog2(MV_MULT);
  localparam int              MVP_W     = ADC_W + MV_MULT_W;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NOW_W-1:0]  now_ms;
    logic [ADC_W-1:0]  adc_value;
  } bms_in_t;

  typedef struct packed {
    logic             load_on;
    logic             adc_request;
    logic             measure_done;
    logic             aborted;
    logic             busy_res;
    logic [MV_W-1:0]  voltage_mv;
    logic [ADC_W-1:0] raw_average;
    logic [LVL_W-1:0] level_byte;
  } bms_out_t;

  typedef struct packed {
    logic [FD_W-1:0]     first_delay_ms;
    logic [PER_W-1:0]    period_ms;
    logic [TO_W-1:0]     timeout_ms;
    logic [SETTLE_W-1:0] settle_ms;
  } bms_cfg_t;

  typedef struct packed {
    logic load_on;
    logic adc_request;
    logic measure_done;
    logic aborted;
    logic busy_res;
  } bms_flags_t;

  // sequencer result handed to the scaling pipeline
  typedef struct packed {
    bms_flags_t       flags;
    logic [SUM_W-1:0] last_sum;
  } bms_mid_t;

endpackage

`default_nettype wire

// File: hdl/bms_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bms_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/battery_measure_sequencer.sv
// path: an accepted item moves through the input, result, average and output registers
// throughput: one item per cycle; input, sequencer, average and millivolt
//   stages each hold one item and advance independently under back-pressure
// the per-item work is set by the sequencer stage, which updates all its state as an item advances
// reset: synchronous active-low rst_n clears the pipeline, the sequencer to idle
//   and the registers to their defaults; it takes effect at the next clock edge
`timescale 1ns / 1ps
`default_nettype none

module battery_measure_sequencer #(
  parameter int SAMPLE_COUNT = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bms_chan_if.sink                            in_ch,
  bms_chan_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bms_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bms_pkg::*;

  // configuration, written only while no item is in flight: a rule for the user that the block leaves unenforced
  bms_cfg_t cfg;

  // sequencer to scaling pipeline
  logic     mid_valid;
  logic     mid_ready;
  bms_mid_t mid_data;

  bms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register, measurement state machine and result register: start on first delay or
  // period, load settle, sample collection, timeout abort
  bms_ctrl #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  // average of the last completed sum, then millivolt scaling; the output
  // register here decouples the result side from the input side
  bms_scale #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_data   (mid_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

`default_nettype wire

// File: hdl/bms_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bms_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bms_pkg::bms_cfg_t                   cfg
);
  import bms_pkg::*;

  bms_cfg_t cfg_r;
  bms_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_DELAY: cfg_nxt.first_delay_ms = cfg_wdata[FD_W-1:0];
        CFG_PERIOD:      cfg_nxt.period_ms      = cfg_wdata[PER_W-1:0];
        CFG_TIMEOUT:     cfg_nxt.timeout_ms     = cfg_wdata[TO_W-1:0];
        CFG_SETTLE:      cfg_nxt.settle_ms      = cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_delay_ms <= FIRST_DELAY_RST;
      cfg_r.period_ms      <= PERIOD_RST;
      cfg_r.timeout_ms     <= TIMEOUT_RST;
      cfg_r.settle_ms      <= SETTLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/bms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bms_ctrl #(
  parameter int SAMPLE_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bms_pkg::bms_cfg_t cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bms_pkg::bms_in_t  in_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output bms_pkg::bms_mid_t      dn_data
);
  import bms_pkg::*;

  localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SETTLE, ST_COLLECT} phase_t;

  // input register
  logic    s0_vld_r;
  bms_in_t s0_item_r;
  // sequencer state
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [NOW_W-1:0] seq_start_r, seq_start_nxt;
  logic [NOW_W-1:0] last_meas_r, last_meas_nxt;
  logic             measured_r, measured_nxt;
  logic [SUM_W-1:0] last_sum_r, last_sum_nxt;
  logic             load_r, load_nxt;
  // result register
  logic       s1_vld_r;
  bms_mid_t   s1_data_r;
  bms_flags_t flags_nxt;

  logic             s1_rdy;
  logic             s0_adv;
  logic [NOW_W-1:0] elapsed;
  logic [NOW_W-1:0] since_meas;
  logic             start;
  logic             timed_out;
  logic [SUM_W-1:0] sum_add;

  assign s1_rdy   = !s1_vld_r || dn_ready;
  assign s0_adv   = s0_vld_r && s1_rdy;
  assign in_ready = !s0_vld_r || s1_rdy;

  assign elapsed    = s0_item_r.now_ms - seq_start_r;
  assign since_meas = s0_item_r.now_ms - last_meas_r;
  assign start      = (!measured_r && (s0_item_r.now_ms > NOW_W'(cfg.first_delay_ms))) ||
                      (since_meas >= cfg.period_ms);
  assign timed_out  = elapsed > NOW_W'(cfg.timeout_ms);
  assign sum_add    = sum_r + SUM_W'(s0_item_r.adc_value);

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    seq_start_nxt = seq_start_r;
    last_meas_nxt = last_meas_r;
    measured_nxt  = measured_r;
    last_sum_nxt  = last_sum_r;
    load_nxt      = load_r;
    flags_nxt     = '0;
    if (s0_adv) begin
      case (s0_item_r.mode)
        MODE_POLL: begin
          case (phase_r)
            ST_IDLE: begin
              // start: load on, settle timer runs from this poll
              if (start) begin
                measured_nxt  = 1'b1;
                last_meas_nxt = s0_item_r.now_ms;
                seq_start_nxt = s0_item_r.now_ms;
                sum_nxt       = '0;
                load_nxt      = 1'b1;
                phase_nxt     = ST_SETTLE;
              end
            end
            ST_SETTLE: begin
              if (timed_out) begin
                phase_nxt         = ST_IDLE;
                load_nxt          = 1'b0;
                flags_nxt.aborted = 1'b1;
              end else if (elapsed >= NOW_W'(cfg.settle_ms)) begin
                phase_nxt             = ST_COLLECT;
                cnt_nxt               = '0;
                flags_nxt.adc_request = 1'b1;
              end
            end
            ST_COLLECT: begin
              if (timed_out) begin
                phase_nxt         = ST_IDLE;
                load_nxt          = 1'b0;
                flags_nxt.aborted = 1'b1;
              end
            end
            default: ;
          endcase
        end
        MODE_SAMPLE: begin
          if (phase_r == ST_COLLECT) begin
            sum_nxt = sum_add;
            if (cnt_r == CNT_LAST) begin
              last_sum_nxt           = sum_add;
              phase_nxt              = ST_IDLE;
              load_nxt               = 1'b0;
              flags_nxt.measure_done = 1'b1;
            end else begin
              cnt_nxt               = cnt_r + CNT_W'(1);
              flags_nxt.adc_request = 1'b1;
            end
          end
        end
        MODE_FORCE: measured_nxt = 1'b0;
        default: ;
      endcase
      flags_nxt.load_on  = load_nxt;
      flags_nxt.busy_res = phase_nxt != ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      phase_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      seq_start_r <= '0;
      last_meas_r <= '0;
      measured_r  <= 1'b0;
      last_sum_r  <= '0;
      load_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_vld_r <= in_valid;
      end
      if (s1_rdy) begin
        s1_vld_r <= s0_vld_r;
      end
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      seq_start_r <= seq_start_nxt;
      last_meas_r <= last_meas_nxt;
      measured_r  <= measured_nxt;
      last_sum_r  <= last_sum_nxt;
      load_r      <= load_nxt;
    end
    if (in_ready && in_valid) begin
      s0_item_r <= in_data;
    end
    if (s0_adv) begin
      s1_data_r.flags    <= flags_nxt;
      s1_data_r.last_sum <= last_sum_nxt;
    end
  end

  assign dn_valid = s1_vld_r;
  assign dn_data  = s1_data_r;

  // load drive follows the running sequence exactly
  a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
    load_r == (phase_r != ST_IDLE))
    else $error("load state out of step with phase");

  a_done_abort: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> !(s1_data_r.flags.measure_done && s1_data_r.flags.aborted))
    else $error("item both completed and aborted");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_data_r.flags.adc_request) |->
      (s1_data_r.flags.busy_res && s1_data_r.flags.load_on))
    else $error("sample requested outside a running sequence");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_data_r.flags.measure_done) |->
      (!s1_data_r.flags.busy_res && !s1_data_r.flags.load_on))
    else $error("sequence still running after completion");

  a_sum_updates: assert property (@(posedge clk) disable iff (!rst_n)
    (!s0_adv && !$past(!rst_n)) |=> $stable(sum_r) || $past(!rst_n))
    else $error("sample sum changed without an item");

endmodule

`default_nettype wire

// File: hdl/bms_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module bms_scale #(
  parameter int SAMPLE_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire bms_pkg::bms_mid_t up_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bms_pkg::bms_out_t      out_data
);
  import bms_pkg::*;

  // average by reciprocal multiply, exact for any 16-bit sum
  localparam int DIV_SHIFT = SUM_W + 5;
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
  localparam int DIVP_W    = DIV_SHIFT + SUM_W + 1;

  logic             s2_vld_r;
  bms_flags_t       s2_flags_r;
  logic [ADC_W-1:0] s2_raw_r;
  logic             out_vld_r;
  bms_out_t         out_data_r;

  logic             s2_rdy;
  logic             s3_rdy;
  logic [DIVP_W-1:0] div_prod;
  logic [SUM_W-1:0]  avg_q;
  logic [ADC_W-1:0]  raw_nxt;
  logic [MVP_W-1:0]  mv_prod;
  bms_out_t          out_nxt;

  assign s3_rdy   = !out_vld_r || out_ready;
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign up_ready = s2_rdy;

  assign div_prod = DIVP_W'(up_data.last_sum) * DIVP_W'(DIV_MULT);
  assign avg_q    = div_prod[DIV_SHIFT +: SUM_W];
  assign raw_nxt  = (avg_q > SUM_W'(ADC_MAX)) ? ADC_MAX : avg_q[ADC_W-1:0];

  assign mv_prod = MVP_W'(s2_raw_r) * MVP_W'(MV_MULT);

  always_comb begin
    out_nxt.load_on      = s2_flags_r.load_on;
    out_nxt.adc_request  = s2_flags_r.adc_request;
    out_nxt.measure_done = s2_flags_r.measure_done;
    out_nxt.aborted      = s2_flags_r.aborted;
    out_nxt.busy_res     = s2_flags_r.busy_res;
    out_nxt.voltage_mv   = mv_prod[MV_SHIFT +: MV_W];
    out_nxt.raw_average  = s2_raw_r;
    out_nxt.level_byte   = s2_raw_r[ADC_W-1 -: LVL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_vld_r <= up_valid;
      end
      if (s3_rdy) begin
        out_vld_r <= s2_vld_r;
      end
    end
    if (s2_rdy && up_valid) begin
      s2_flags_r <= up_data.flags;
      s2_raw_r   <= raw_nxt;
    end
    if (s3_rdy && s2_vld_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: tb/battery_measure_checker.sv
`timescale 1ns / 1ps

module battery_measure_checker
  import bms_pkg::*;
#(
  parameter int SAMPLE_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  bms_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  bms_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_cnt,
  output int                    open_results
);

  localparam int unsigned MV_SCALE_NUM = 7400;
  localparam int unsigned MV_SCALE_DEN = 'hab0;
  localparam int unsigned RAW_CEIL     = 4095;

  // register copies
  logic [FD_W-1:0]     first_wait;
  logic [PER_W-1:0]    meas_period;
  logic [TO_W-1:0]     run_limit;
  logic [SETTLE_W-1:0] settle_wait;

  // sequencer state
  int unsigned      seq_phase;
  logic [SUM_W-1:0] acc_sum;
  logic [NOW_W-1:0] run_start_ms;
  logic [NOW_W-1:0] prev_meas_ms;
  logic             have_reading;
  logic [MV_W-1:0]  held_mv;
  logic [ADC_W-1:0] held_avg;
  logic             load_drive;

  bms_out_t    expected_q[$];
  int unsigned result_idx;

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("[%0t] result %0d %s: expected 0x%0h, got 0x%0h",
             $time, result_idx, what, want, got);
    mismatch_cnt++;
  endtask

  // one item through the sequencer, result after the item
  task automatic step_sequencer(input bms_in_t it, output bms_out_t res);
    logic        req;
    logic        done;
    logic        abrt;
    logic        quiet;
    logic [31:0] span;
    logic [31:0] avg;
    req   = 1'b0;
    done  = 1'b0;
    abrt  = 1'b0;
    quiet = 1'b0;
    case (it.mode)
      MODE_POLL: begin
        if (seq_phase == 0) begin
          if ((!have_reading && it.now_ms > {16'h0, first_wait}) ||
              (it.now_ms - prev_meas_ms) >= meas_period) begin
            have_reading = 1'b1;
            prev_meas_ms = it.now_ms;
            seq_phase    = 1;
            acc_sum      = '0;
          end else begin
            quiet = 1'b1;
          end
        end
        if (!quiet) begin
          if (seq_phase == 1) run_start_ms = it.now_ms;
          span = it.now_ms - run_start_ms;
          if (span > {16'h0, run_limit}) begin
            seq_phase  = 0;
            load_drive = 1'b0;
            abrt       = 1'b1;
          end else if (seq_phase == 1) begin
            load_drive = 1'b1;
            seq_phase  = 2;
          end else if (seq_phase == 2 && span >= {24'h0, settle_wait}) begin
            seq_phase = 3;
            req       = 1'b1;
          end
        end
      end
      MODE_SAMPLE: begin
        if (seq_phase >= 3) begin
          seq_phase++;
          acc_sum = acc_sum + {4'h0, it.adc_value};
          if (seq_phase > 2 + SAMPLE_COUNT) begin
            avg = 32'(acc_sum) / 32'(SAMPLE_COUNT);
            if (avg > RAW_CEIL) avg = RAW_CEIL;
            held_mv    = MV_W'((avg * MV_SCALE_NUM) / MV_SCALE_DEN);
            held_avg   = avg[ADC_W-1:0];
            seq_phase  = 0;
            load_drive = 1'b0;
            done       = 1'b1;
          end else begin
            req = 1'b1;
          end
        end
      end
      MODE_FORCE: have_reading = 1'b0;
      default: ;
    endcase
    res.load_on      = load_drive;
    res.adc_request  = req;
    res.measure_done = done;
    res.aborted      = abrt;
    res.busy_res     = (seq_phase != 0);
    res.voltage_mv   = held_mv;
    res.raw_average  = held_avg;
    res.level_byte   = held_avg[ADC_W-1:4];
  endtask

  always @(posedge clk) begin
    bms_out_t want;
    bms_out_t res;
    if (!rst_n) begin
      first_wait   = FIRST_DELAY_RST;
      meas_period  = PERIOD_RST;
      run_limit    = TIMEOUT_RST;
      settle_wait  = SETTLE_RST;
      seq_phase    = 0;
      acc_sum      = '0;
      run_start_ms = '0;
      prev_meas_ms = '0;
      have_reading = 1'b0;
      held_mv      = '0;
      held_avg     = '0;
      load_drive   = 1'b0;
      result_idx   = 0;
      mismatch_cnt = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_DELAY: first_wait  = cfg_wdata[FD_W-1:0];
          CFG_PERIOD:      meas_period = cfg_wdata[PER_W-1:0];
          CFG_TIMEOUT:     run_limit   = cfg_wdata[TO_W-1:0];
          CFG_SETTLE:      settle_wait = cfg_wdata[SETTLE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("result with nothing expected", '0, out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.load_on !== want.load_on)
            flag_mismatch("load_on", want.load_on, out_data.load_on);
          if (out_data.adc_request !== want.adc_request)
            flag_mismatch("adc_request", want.adc_request, out_data.adc_request);
          if (out_data.measure_done !== want.measure_done)
            flag_mismatch("measure_done", want.measure_done, out_data.measure_done);
          if (out_data.aborted !== want.aborted)
            flag_mismatch("aborted", want.aborted, out_data.aborted);
          if (out_data.busy_res !== want.busy_res)
            flag_mismatch("busy_res", want.busy_res, out_data.busy_res);
          if (out_data.voltage_mv !== want.voltage_mv)
            flag_mismatch("voltage_mv", want.voltage_mv, out_data.voltage_mv);
          if (out_data.raw_average !== want.raw_average)
            flag_mismatch("raw_average", want.raw_average, out_data.raw_average);
          if (out_data.level_byte !== want.level_byte)
            flag_mismatch("level_byte", want.level_byte, out_data.level_byte);
        end
        result_idx++;
      end
      if (in_valid && in_ready) begin
        step_sequencer(in_data, res);
        expected_q.push_back(res);
      end
    end
    open_results = expected_q.size();
  end

endmodule

// File: tb/tb_battery_measure_sequencer.sv
`timescale 1ns / 1ps

module tb_battery_measure_sequencer;
  import bms_pkg::*;

  localparam int SAMPLES       = 4;
  localparam int RANDOM_ITEMS  = 400;
  localparam int PHASE_ITEMS   = 50;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  // mode code the block does not use
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_cnt;
  int open_results;
  int sent_cnt;
  int stall_cnt;

  // idling controls for the sender and the receiver
  bit tx_steady;
  bit rx_steady;
  bit hold_req;

  // running millisecond clock and the settings currently loaded
  logic [NOW_W-1:0]    clock_ms;
  logic [FD_W-1:0]     cur_first;
  logic [PER_W-1:0]    cur_period;
  logic [TO_W-1:0]     cur_timeout;
  logic [SETTLE_W-1:0] cur_settle;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bms_chan_if #(.T(bms_in_t))  in_if ();
  bms_chan_if #(.T(bms_out_t)) out_if ();

  battery_measure_sequencer #(
    .SAMPLE_COUNT(SAMPLES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  battery_measure_checker #(
    .SAMPLE_COUNT(SAMPLES)
  ) i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_data     (in_if.data),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_data    (out_if.data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatch_cnt(mismatch_cnt),
    .open_results(open_results)
  );

  // adc value with the two extremes weighted up
  function automatic logic [ADC_W-1:0] adc_pick();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ADC_MAX;
      default: return ADC_W'($urandom_range(0, ADC_MAX));
    endcase
  endfunction

  // offer one item, entered and left at a falling edge; valid stays high on return
  task automatic send_item(input logic [MODE_W-1:0] kind, input logic [NOW_W-1:0] stamp,
                           input logic [ADC_W-1:0] sample);
    while (!tx_steady && $urandom_range(0, 99) < 24) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = '{mode: kind, now_ms: stamp, adc_value: sample};
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    if (kind != MODE_UNUSED) sent_cnt++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (open_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
  endtask

  // register writes only with nothing in flight
  task automatic apply_settings(input logic [FD_W-1:0] fd, input logic [PER_W-1:0] per,
                                input logic [TO_W-1:0] to, input logic [SETTLE_W-1:0] st);
    wait_drained();
    write_reg(CFG_FIRST_DELAY, CFG_DATA_W'(fd));
    write_reg(CFG_PERIOD, CFG_DATA_W'(per));
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(to));
    write_reg(CFG_SETTLE, CFG_DATA_W'(st));
    cfg_we      = 1'b0;
    cur_first   = fd;
    cur_period  = per;
    cur_timeout = to;
    cur_settle  = st;
  endtask

  // one random stretch of traffic, mostly a complete measurement
  task automatic run_burst(input bit force_heavy);
    logic [NOW_W-1:0] t0;
    logic [NOW_W-1:0] t_req;
    logic [NOW_W-1:0] slack;
    int               pick;
    int               n;
    // jump far enough that an idle sequencer is due again
    clock_ms = clock_ms + cur_period + cur_timeout + cur_settle + $urandom_range(1, 20);
    t0       = clock_ms;
    pick     = $urandom_range(0, 99);
    // force clears the measured flag so the first-delay rule applies again
    if (force_heavy || $urandom_range(0, 3) == 0)
      send_item(MODE_FORCE, $urandom, adc_pick());
    if (pick < 70) begin
      // start, a few settle polls, first request, then the samples
      send_item(MODE_POLL, t0, adc_pick());
      n = $urandom_range(0, 2);
      repeat (n) send_item(MODE_POLL, t0 + $urandom_range(0, cur_settle), adc_pick());
      slack = (cur_timeout >= cur_settle) ? cur_timeout - cur_settle : '0;
      if (slack > 30) slack = 30;
      t_req = t0 + cur_settle + $urandom_range(0, slack);
      send_item(MODE_POLL, t_req, adc_pick());
      repeat (SAMPLES) begin
        // polls inside the timeout window and stray forces leave collection alone
        if ($urandom_range(0, 9) == 0) send_item(MODE_POLL, t_req, adc_pick());
        if ($urandom_range(0, 19) == 0) send_item(MODE_FORCE, $urandom, adc_pick());
        send_item(MODE_SAMPLE, $urandom, adc_pick());
      end
      clock_ms = t_req;
    end else if (pick < 85) begin
      // sequence that runs out of time, possibly with some samples in
      send_item(MODE_POLL, t0, adc_pick());
      send_item(MODE_POLL, t0 + cur_settle, adc_pick());
      n = $urandom_range(0, SAMPLES - 1);
      repeat (n) send_item(MODE_SAMPLE, $urandom, adc_pick());
      clock_ms = t0 + cur_timeout + 1 + $urandom_range(0, 50);
      send_item(MODE_POLL, clock_ms, adc_pick());
    end else begin
      // noise: any mode, times near the clock or anywhere
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          send_item(MODE_W'($urandom_range(0, 3)), $urandom, adc_pick());
        else
          send_item(MODE_W'($urandom_range(0, 3)), clock_ms + $urandom_range(0, 40), adc_pick());
      end
    end
  endtask

  // receiver: random ready, with one long hold-off when asked for
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_if.ready = rx_steady || ($urandom_range(0, 99) >= 24);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cnt <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb_battery_measure_sequencer: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int                  target;
    int                  phase_start;
    logic [TO_W-1:0]     limit_pick;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    sent_cnt    = 0;
    clock_ms    = '0;
    cur_first   = FIRST_DELAY_RST;
    cur_period  = PERIOD_RST;
    cur_timeout = TIMEOUT_RST;
    cur_settle  = SETTLE_RST;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed part, register defaults
    send_item(MODE_SAMPLE, '0, ADC_MAX);          // sample while idle is ignored
    send_item(MODE_UNUSED, '1, ADC_MAX);          // unused mode changes nothing
    send_item(MODE_POLL, 32'd0, '0);              // before the first delay
    send_item(MODE_POLL, 32'd750, '0);            // equal to first delay, no start yet
    send_item(MODE_POLL, 32'd751, '0);            // first start, load on
    send_item(MODE_SAMPLE, '0, 12'habc);          // sample while settling is ignored
    send_item(MODE_POLL, 32'd755, '0);            // settle not over
    send_item(MODE_POLL, 32'd756, '0);            // settle just over, first request
    send_item(MODE_FORCE, '1, '0);                // force mid-sequence, sequence goes on
    repeat (SAMPLES) send_item(MODE_SAMPLE, '0, ADC_MAX);  // full-scale average
    send_item(MODE_POLL, 32'd756, '0);            // forced, so first-delay rule starts again
    send_item(MODE_POLL, 32'd761, '0);
    repeat (SAMPLES) send_item(MODE_SAMPLE, '1, '0);       // zero average
    send_item(MODE_FORCE, '0, '0);
    send_item(MODE_POLL, 32'd900, '0);
    send_item(MODE_POLL, 32'd1001, '0);           // timeout while settling
    send_item(MODE_POLL, 32'd1002, '0);           // period not elapsed
    send_item(MODE_POLL, 32'd45900, '0);          // period exactly elapsed
    send_item(MODE_POLL, 32'd46000, '0);          // elapsed equal to timeout, no abort
    clock_ms = 32'd46000;

    // random part, one register setting per phase
    target = sent_cnt + RANDOM_ITEMS;
    for (int ph = 0; sent_cnt < target; ph++) begin
      case (ph % 8)
        1: apply_settings('0, '0, '0, '0);
        4: apply_settings('1, '1, '1, '1);
        6: apply_settings(FIRST_DELAY_RST, PERIOD_RST, TIMEOUT_RST, SETTLE_RST);
        default: begin
          limit_pick = TO_W'($urandom_range(10, 120));
          apply_settings(FD_W'($urandom_range(0, 40)), PER_W'($urandom_range(0, 80)),
                         limit_pick, SETTLE_W'($urandom_range(0, 10)));
        end
      endcase
      // millisecond counter wraps during this phase
      if (ph % 8 == 3) clock_ms = 32'hffff_ffc0;
      // one phase with no idling on either side
      tx_steady = (ph % 8 == 5);
      rx_steady = (ph % 8 == 5);
      // long receiver hold-off while items keep coming
      if (ph % 8 == 2) hold_req = 1'b1;
      phase_start = sent_cnt;
      while (sent_cnt - phase_start < PHASE_ITEMS && sent_cnt < target)
        run_burst(ph % 8 == 4);
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && open_results == 0) begin
      $display("tb_battery_measure_sequencer: done, clean");
    end else begin
      $display("tb_battery_measure_sequencer: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/bms_pkg.sv
hdl/bms_chan_if.sv
hdl/bms_cfg_regs.sv
hdl/bms_ctrl.sv
hdl/bms_scale.sv
hdl/battery_measure_sequencer.sv
tb/battery_measure_checker.sv
tb/tb_battery_measure_sequencer.sv
